[design/mt19937_word_generator_unit_macros.svh]
// ----------------------------------------------------------------------------
// MT19937 word generator assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef MT19937_WORD_GENERATOR_UNIT_MACROS_SVH
`define MT19937_WORD_GENERATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTWG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MTWG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[design/mtwg_pkg.sv]
// ----------------------------------------------------------------------------
// MT19937 word generator package
// Constants, state memory request type and arithmetic helpers.
// ----------------------------------------------------------------------------
package mtwg_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned WORD_COUNT = 624;
	localparam int unsigned MID_OFFSET = 397;
	localparam int unsigned IDX_W      = 10;

	localparam logic [IDX_W-1:0]  UNSEEDED_INDEX = IDX_W'(625);
	localparam logic [IDX_W-1:0]  LAST_INDEX     = IDX_W'(WORD_COUNT - 1);
	localparam logic [WORD_W-1:0] SEED_RESET     = 32'd4357;
	localparam logic [WORD_W-1:0] LCG_MULT       = 32'd69069;
	localparam logic [WORD_W-1:0] TWIST_MATRIX   = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] HIGH_BIT       = 32'h8000_0000;
	localparam logic [WORD_W-1:0] LOW_BITS       = 32'h7fff_ffff;
	localparam logic [WORD_W-1:0] TEMPER_B       = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C       = 32'hefc6_0000;

	// One cycle's worth of accesses to the state memory.
	typedef struct packed {
		logic              rd_en;
		logic [IDX_W-1:0]  rd_addr_a;
		logic [IDX_W-1:0]  rd_addr_b;
		logic              wr_en;
		logic [IDX_W-1:0]  wr_addr;
		logic [WORD_W-1:0] wr_data;
	} mtwg_ram_req_t;

	// One step of the 69069 linear congruential seeding, modulo 2^32.
	function automatic logic [WORD_W-1:0] lcg_next(input logic [WORD_W-1:0] s);
		logic [2*WORD_W-1:0] prod;
		prod = s * LCG_MULT;
		return prod[WORD_W-1:0] + WORD_W'(1);
	endfunction

endpackage

[design/mtwg_state_ram.sv]
// ----------------------------------------------------------------------------
// MT19937 state memory
// 624 x 32 synchronous memory, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mtwg_state_ram
	import mtwg_pkg::*;
(
	input  logic              clk,
	input  mtwg_ram_req_t     req,
	output logic [WORD_W-1:0] rd_data_a,
	output logic [WORD_W-1:0] rd_data_b
);

	logic [WORD_W-1:0] mem [WORD_COUNT];
	logic [WORD_W-1:0] rd_data_a_q;
	logic [WORD_W-1:0] rd_data_b_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Read data only moves on a read, so it holds while the result waits.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_a_q <= mem[req.rd_addr_a];
			rd_data_b_q <= mem[req.rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

[design/mtwg_twist_unit.sv]
// ----------------------------------------------------------------------------
// MT19937 twist and temper
// Builds the new state word from three old ones and tempers it for output.
// ----------------------------------------------------------------------------
module mtwg_twist_unit
	import mtwg_pkg::*;
(
	input  logic [WORD_W-1:0] cur_word,
	input  logic [WORD_W-1:0] next_word,
	input  logic [WORD_W-1:0] mid_word,
	output logic [WORD_W-1:0] new_word,
	output logic [WORD_W-1:0] tempered_word
);

	logic [WORD_W-1:0] y;
	logic [WORD_W-1:0] t1;
	logic [WORD_W-1:0] t2;
	logic [WORD_W-1:0] t3;

	always_comb begin
		y        = (cur_word & HIGH_BIT) | (next_word & LOW_BITS);
		new_word = mid_word ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : '0);
		t1       = new_word ^ (new_word >> 11);
		t2       = t1 ^ ((t1 << 7) & TEMPER_B);
		t3       = t2 ^ ((t2 << 15) & TEMPER_C);
		tempered_word = t3 ^ (t3 >> 18);
	end

endmodule

[design/mt19937_word_generator_unit.sv]
// ----------------------------------------------------------------------------
// A draw is accepted in IDLE, reads in READ and writes its word back in UPDATE,
// where it may wait for the output register; a request that refills the state
// first runs through FILL. A request is only taken from idle, so a new draw is
// taken only after the last has left UPDATE. Reset: seed register to 4357,
// state marked unseeded, memory kept.
// ----------------------------------------------------------------------------
//
// MT19937 word generator, top level.
//
// The 624-word state lives in a synchronous memory with two read ports. A
// draw at index i needs words i, i+1 and i+397 (modulo 624). Word i is
// already held in cur_q, because it was read as "word i+1" by the previous
// draw and nothing writes it in between; so a draw issues only two reads
// (i+1 and i+397) in the READ state and writes the twisted word back at i in
// the UPDATE state. No draw reads an address written by the draw just before
// it, so no forwarding path is needed.
//
// A refill runs two 69069 steps per state word, one multiply per cycle,
// writing the word on the second step. Word 0 is captured into cur_q on its
// way into the memory so the first draw can follow directly.
//
// The output word sits in a register. A new request is taken as soon as the
// sequencer is idle, even while a previous word still waits; its UPDATE step
// then waits until the output register is free.
// ----------------------------------------------------------------------------
module mt19937_word_generator_unit
	import mtwg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              seed_we,
	input  logic [WORD_W-1:0] seed_wdata,
	input  logic              req_valid,
	output logic              req_stall,
	input  logic              restart,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [WORD_W-1:0] random_word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ,
		ST_UPDATE
	} state_t;

	state_t            state_q;
	logic [WORD_W-1:0] seed_q;
	logic [IDX_W-1:0]  index_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] lcg_q;
	logic [15:0]       hi_q;
	logic [IDX_W-1:0]  fill_idx_q;
	logic              fill_phase_q;
	logic              rsp_valid_q;
	logic [WORD_W-1:0] random_word_q;

	mtwg_ram_req_t     ram_req;
	logic [WORD_W-1:0] rd_next;
	logic [WORD_W-1:0] rd_mid;
	logic [WORD_W-1:0] new_word;
	logic [WORD_W-1:0] tempered_word;
	logic [IDX_W-1:0]  next_idx;
	logic [IDX_W-1:0]  mid_sum;
	logic [IDX_W-1:0]  mid_idx;
	logic [WORD_W-1:0] fill_word;
	logic              req_take;
	logic              out_free;
	logic              seeded;

	// Neighbor addresses of the current index, wrapped at 624.
	always_comb begin
		next_idx = (index_q == LAST_INDEX) ? '0 : index_q + IDX_W'(1);
		mid_sum  = index_q + IDX_W'(MID_OFFSET);
		mid_idx  = (mid_sum >= IDX_W'(WORD_COUNT)) ? mid_sum - IDX_W'(WORD_COUNT) : mid_sum;
	end

	assign fill_word = {hi_q, lcg_q[WORD_W-1:16]};
	assign seeded    = (index_q < IDX_W'(WORD_COUNT));
	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	always_comb begin
		ram_req           = '0;
		ram_req.rd_addr_a = next_idx;
		ram_req.rd_addr_b = mid_idx;
		ram_req.wr_addr   = index_q;
		ram_req.wr_data   = new_word;
		unique case (state_q)
			ST_FILL: begin
				ram_req.wr_en   = fill_phase_q;
				ram_req.wr_addr = fill_idx_q;
				ram_req.wr_data = fill_word;
			end
			ST_READ: begin
				ram_req.rd_en = 1'b1;
			end
			ST_UPDATE: begin
				ram_req.wr_en = out_free;
			end
			default: begin
				ram_req.rd_en = 1'b0;
			end
		endcase
	end

	mtwg_state_ram u_ram (
		.clk       (clk),
		.req       (ram_req),
		.rd_data_a (rd_next),
		.rd_data_b (rd_mid)
	);

	mtwg_twist_unit u_twist (
		.cur_word      (cur_q),
		.next_word     (rd_next),
		.mid_word      (rd_mid),
		.new_word      (new_word),
		.tempered_word (tempered_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			seed_q        <= SEED_RESET;
			index_q       <= UNSEEDED_INDEX;
			cur_q         <= '0;
			lcg_q         <= '0;
			hi_q          <= '0;
			fill_idx_q    <= '0;
			fill_phase_q  <= 1'b0;
			rsp_valid_q   <= 1'b0;
			random_word_q <= '0;
		end else begin
			if (seed_we) begin
				seed_q <= seed_wdata;
			end
			// In UPDATE the word register is loaded below whenever it is free.
			if (rsp_valid_q && !rsp_stall && state_q != ST_UPDATE) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						if (restart || !seeded) begin
							state_q      <= ST_FILL;
							lcg_q        <= seed_q;
							fill_idx_q   <= '0;
							fill_phase_q <= 1'b0;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_FILL: begin
					lcg_q        <= lcg_next(lcg_q);
					fill_phase_q <= !fill_phase_q;
					if (!fill_phase_q) begin
						hi_q <= lcg_q[WORD_W-1:16];
					end else begin
						if (fill_idx_q == '0) begin
							cur_q <= fill_word;
						end
						if (fill_idx_q == LAST_INDEX) begin
							index_q <= '0;
							state_q <= ST_READ;
						end else begin
							fill_idx_q <= fill_idx_q + IDX_W'(1);
						end
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (out_free) begin
						cur_q         <= rd_next;
						index_q       <= next_idx;
						random_word_q <= tempered_word;
						rsp_valid_q   <= 1'b1;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign random_word = random_word_q;

endmodule

[design/mtwg_checker.sv]
// ----------------------------------------------------------------------------
// MT19937 word generator port checker
// Watches the request and result channels of the top level over time.
// ----------------------------------------------------------------------------
`include "mt19937_word_generator_unit_macros.svh"

module mtwg_checker
	import mtwg_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic [WORD_W-1:0] random_word
);

	logic [1:0] pend_q;
	logic       req_fire;
	logic       rsp_fire;
	logic       rsp_held;

	assign req_fire = req_valid && !req_stall;
	assign rsp_fire = rsp_valid && !rsp_stall;
	assign rsp_held = rsp_valid && rsp_stall;

	// Requests taken whose word has not yet been delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_fire) - 2'(rsp_fire);
		end
	end

	`MTWG_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(random_word), "held word changed")
	`MTWG_ASSERT_NEXT(a_req_spacing, req_fire, req_stall, "request taken in back-to-back cycles")
	`MTWG_ASSERT_NOW(a_rsp_has_req, rsp_valid, pend_q != 2'd0, "result word without a request")
	`MTWG_ASSERT_NOW(a_pend_bound, 1'b1, pend_q != 2'd3, "more than two requests in flight")

endmodule

bind mt19937_word_generator_unit mtwg_checker u_mtwg_checker (.*);
